// File: hdl/sts_pkg.sv
// Shared types, codes and defaults for the sorted table search engine.
`default_nettype none

package sts_pkg;

    // Default number of table entries.
    localparam int TABLE_DEPTH_DEF = 32;

    // Request codes carried on the input tuser.
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_LOAD   = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    // Search mode register codes.
    localparam logic MODE_BINARY = 1'b0;
    localparam logic MODE_LINEAR = 1'b1;

    // Result status codes carried on the output tuser.
    localparam logic [2:0] ST_LOADED  = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_FOUND   = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_LINEAR,
        S_BIN_PROBE,
        S_BIN_CMP,
        S_DONE
    } state_t;

    // One result word as it leaves the sequencer.
    typedef struct packed {
        logic [2:0] status;
        logic [4:0] found_index;
        logic [5:0] comparison_count;
        logic [5:0] entries_held;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/sts_table_ram.sv
// Table storage: one write port and one registered read port.
`default_nettype none

module sts_table_ram
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output logic signed [31:0]        rd_data,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic signed [31:0]   wr_data
);

    logic signed [31:0] mem [TABLE_DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/sts_seq.sv
// Sequencer that runs insertion, linear scan and binary search against the table memory.
`default_nettype none

module sts_seq
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH),
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 search_mode,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           in_req,
    input  wire logic signed [31:0]   in_value,
    input  wire logic                 res_ready,
    output logic                      res_valid,
    output result_t                   res,
    output logic                      rd_en,
    output logic [AW-1:0]             rd_addr,
    input  wire logic signed [31:0]   rd_data,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic signed [31:0]        wr_data
);

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [31:0] key_reg, key_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hx_reg, hx_next;
    logic [CW-1:0]      mid_reg, mid_next;
    logic [CW-1:0]      cmp_reg, cmp_next;
    result_t            res_reg, res_next;

    logic               accept;
    logic               table_full;
    logic               ins_shift;
    logic               lin_hit;
    logic               lin_last;
    logic               bin_empty;
    logic               bin_hit;
    logic               bin_less;
    logic [CW-1:0]      bin_mid;
    logic [CW-1:0]      cmp_inc;

    // Conditions shared by the state and datapath logic.
    assign accept     = in_valid && (state_reg == S_IDLE);
    assign table_full = (count_reg == CW'(TABLE_DEPTH));
    assign ins_shift  = (pos_reg != '0) && (rd_data > key_reg);
    assign lin_hit    = (rd_data == key_reg);
    assign lin_last   = ((idx_reg + CW'(1)) == count_reg);
    assign bin_empty  = (lo_reg >= hx_reg);
    assign bin_mid    = lo_reg + ((hx_reg - CW'(1) - lo_reg) >> 1);
    assign bin_hit    = (rd_data == key_reg);
    assign bin_less   = (rd_data < key_reg);
    assign cmp_inc    = cmp_reg + CW'(1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_req)
                        REQ_CLEAR: state_next = S_DONE;
                        REQ_LOAD:  state_next = table_full ? S_DONE : S_INSERT;
                        REQ_SEARCH: begin
                            state_next = (search_mode == MODE_LINEAR) ? S_LINEAR
                                                                      : S_BIN_PROBE;
                        end
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_INSERT: begin
                if (!ins_shift) begin
                    state_next = S_DONE;
                end
            end
            S_LINEAR: begin
                if (count_reg == '0 || lin_hit || lin_last) begin
                    state_next = S_DONE;
                end
            end
            S_BIN_PROBE: state_next = bin_empty ? S_DONE : S_BIN_CMP;
            S_BIN_CMP:   state_next = bin_hit ? S_DONE : S_BIN_PROBE;
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Handshake and memory port outputs.
    always_comb begin
        in_ready  = (state_reg == S_IDLE);
        res_valid = (state_reg == S_DONE);
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = pos_reg[AW-1:0];
        wr_data   = key_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && in_req == REQ_LOAD) begin
                    // Fetch the top entry, the first candidate to move up.
                    rd_en   = 1'b1;
                    rd_addr = AW'(count_reg - CW'(1));
                end else if (accept && in_req == REQ_SEARCH) begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
            end
            S_INSERT: begin
                // Move the larger entry up, or drop the new value into the gap.
                wr_en   = 1'b1;
                wr_data = ins_shift ? rd_data : key_reg;
                rd_en   = ins_shift;
                rd_addr = AW'(pos_reg - CW'(2));
            end
            S_LINEAR: begin
                rd_en   = 1'b1;
                rd_addr = AW'(idx_reg + CW'(1));
            end
            S_BIN_PROBE: begin
                rd_en   = !bin_empty;
                rd_addr = AW'(bin_mid);
            end
            S_BIN_CMP: begin
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        count_next = count_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        lo_next    = lo_reg;
        hx_next    = hx_reg;
        mid_next   = mid_reg;
        cmp_next   = cmp_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    key_next = in_value;
                    pos_next = count_reg;
                    idx_next = '0;
                    lo_next  = '0;
                    hx_next  = count_reg;
                    cmp_next = '0;
                    res_next.found_index      = '0;
                    res_next.comparison_count = '0;
                    res_next.entries_held     = 6'(count_reg);
                    unique case (in_req)
                        REQ_CLEAR: begin
                            count_next            = '0;
                            res_next.status       = ST_CLEARED;
                            res_next.entries_held = '0;
                        end
                        REQ_LOAD: begin
                            res_next.status = table_full ? ST_FULL : ST_LOADED;
                        end
                        default: begin
                            res_next.status = ST_MISSING;
                        end
                    endcase
                end
            end
            S_INSERT: begin
                if (ins_shift) begin
                    pos_next = pos_reg - CW'(1);
                end else begin
                    count_next            = count_reg + CW'(1);
                    res_next.entries_held = 6'(count_reg + CW'(1));
                end
            end
            S_LINEAR: begin
                if (count_reg != '0) begin
                    res_next.comparison_count = 6'(idx_reg + CW'(1));
                    if (lin_hit) begin
                        res_next.status      = ST_FOUND;
                        res_next.found_index = 5'(idx_reg);
                    end
                end
                idx_next = idx_reg + CW'(1);
            end
            S_BIN_PROBE: begin
                mid_next = bin_mid;
            end
            S_BIN_CMP: begin
                cmp_next                  = cmp_inc;
                res_next.comparison_count = 6'(cmp_inc);
                if (bin_hit) begin
                    res_next.status      = ST_FOUND;
                    res_next.found_index = 5'(mid_reg);
                end else if (bin_less) begin
                    lo_next = mid_reg + CW'(1);
                end else begin
                    hx_next = mid_reg;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        lo_reg  <= lo_next;
        hx_reg  <= hx_next;
        mid_reg <= mid_next;
        cmp_reg <= cmp_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: hdl/sorted_table_search_engine.sv
// Top level of the sorted table search engine: mode register, output stage and wiring.
//
// Usage: each input word carries a request kind on s_axis_tuser (clear, load or
// search) and a signed 32-bit value on s_axis_tdata. Every clear, load or search
// word produces exactly one result word on the m_axis channel; the unused request
// kind is taken and produces nothing. Loads keep the table in ascending order by
// insertion; searches run a binary search or a linear scan as cfg_wr_data last
// written selects (0 binary, 1 linear).
// Flow: one word is processed at a time. Clear and a load into a full table go
// straight to the result; a load moves each larger entry up one place, top first,
// and then writes the new value into the gap; a linear scan examines the entries
// in order until a match or the last entry; a binary search alternates a probe and
// a compare step, and ends on a probe when the key is not found. The table memory
// read is registered, so each compare uses data read in the step before it.
// The result sits in an output register, so a new word is accepted while an
// earlier result still waits for m_axis_tready; a stalled receiver holds the
// engine only when the next result is ready and the register is still full.
// Reset empties the table, selects binary search and drops any pending result.
`default_nettype none

module sorted_table_search_engine
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // Search mode register write.
    input  wire logic          cfg_wr_en,
    input  wire logic          cfg_wr_data,
    // Input channel.
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [31:0]   s_axis_tdata,   // [31:0] item_value
    input  wire logic [1:0]    s_axis_tuser,   // [1:0] req_type
    // Result channel.
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [23:0]        m_axis_tdata,   // [4:0] found_index, [10:5] comparison_count,
                                               // [16:11] entries_held, [23:17] zero
    output logic [2:0]         m_axis_tuser    // [2:0] status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic               search_mode_reg;
    logic               m_valid_reg, m_valid_next;
    result_t            m_res_reg;
    logic               res_ready;
    logic               res_valid;
    result_t            res;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    // Search mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_mode_reg <= MODE_BINARY;
        end else if (cfg_wr_en) begin
            search_mode_reg <= cfg_wr_data;
        end
    end

    sts_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .search_mode (search_mode_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req      (s_axis_tuser),
        .in_value    (s_axis_tdata),
        .res_ready   (res_ready),
        .res_valid   (res_valid),
        .res         (res),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    sts_table_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Output register: free when empty or being drained this cycle.
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_res_reg.status;
    assign m_axis_tdata  = {7'd0, m_res_reg.entries_held, m_res_reg.comparison_count,
                            m_res_reg.found_index};

endmodule

`default_nettype wire
